[src/fixed_point_atan2_q13_macros.svh]
// Assertion macros shared by the fixed-point atan2 RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIXED_POINT_ATAN2_Q13_MACROS_SVH
`define FIXED_POINT_ATAN2_Q13_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fpa_pkg.sv]
// Types and constants of the fixed-point atan2 block.
// Depends on nothing; imported by every module of the block.
package fpa_pkg;

    typedef struct packed {
        logic signed [15:0] cos_in;
        logic signed [15:0] sin_in;
    } t_fpa_in;

    typedef struct packed {
        logic [15:0] angle_q13;
        logic        zero_vector;
    } t_fpa_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam int DIV_STEPS = 15;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [15:0]        SCALE_LIM  = 16'd128;
    localparam logic [14:0]        Q_FULL     = 15'd16384;
    localparam logic [15:0]        R_SAT      = 16'd32767;
    localparam logic signed [31:0] HALF_Q15   = 32'sh0000_8000;
    localparam logic signed [15:0] K_CUBE     = 16'sd6432;
    localparam logic signed [15:0] K_LIN      = 16'sd32168;
    localparam logic [15:0]        Q15_QPI    = 16'd25736;
    localparam logic [15:0]        Q13_PI     = 16'd25736;
    localparam logic [15:0]        Q13_TWO_PI = 16'd51472;
    localparam logic [15:0]        ZERO_ANGLE = 16'hFFFF;

endpackage

[src/fpa_div.sv]
// Restoring divider producing a 15-bit quotient, one bit per cycle.
// Depends on fpa_pkg and the assertion macro header.
`include "fixed_point_atan2_q13_macros.svh"

module fpa_div import fpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_num,
    input  logic [8:0]  i_den,
    output t_div_stat   o_stat,
    output logic [14:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [9:0]        r_rem;
    logic [8:0]        r_den;
    logic [14:0]       r_quot;
    logic [9:0]        w_trial;
    logic [9:0]        w_diff;
    logic              w_ge;

    assign w_trial = (r_cnt == '0) ? r_rem : {r_rem[8:0], 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff : w_trial;
            r_quot <= {r_quot[13:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

    `FPA_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `FPA_ASSERT_NOW(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while still busy")
    `FPA_ASSERT_NOW(a_div_quot_range, i_clk, i_rst_n, r_done, r_quot <= Q_FULL, "quotient above one")

endmodule

[src/fpa_mulrnd.sv]
// Shared signed 16x16 multiplier with Q15 rounding and a registered result.
// Depends on fpa_pkg.
module fpa_mulrnd import fpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic signed [15:0] o_p
);

    logic signed [31:0] w_prod;
    logic signed [31:0] w_sum;
    logic signed [15:0] r_p;

    assign w_prod = i_a * i_b;
    assign w_sum  = w_prod + HALF_Q15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sum[30:15];
        end
    end

    assign o_p = r_p;

endmodule

[src/fixed_point_atan2_q13.sv]
// Top level of the fixed-point four-quadrant atan2 block.
// Depends on fpa_pkg, fpa_div, fpa_mulrnd and the assertion macro header.
//
// A request is taken when start is high and busy is low; the angle comes back
// on o_res for one cycle with o_done high, and must be taken in that cycle.
// A zero vector answers in the cycle after the request. Any other request
// answers once the magnitudes are halved one step per cycle (up to eight
// steps), a restoring divider forms the ratio, and one shared multiplier
// forms the four polynomial products.
// A new request may be taken in the cycle that o_done is high.
`include "fixed_point_atan2_q13_macros.svh"

module fixed_point_atan2_q13 import fpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_fpa_in  i_req,
    output logic     busy,
    output logic     o_done,
    output t_fpa_out o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_DIV_WAIT,
        S_MUL,
        S_SUM,
        S_FIX
    } t_state;

    t_state             r_state;
    logic [15:0]        r_ac;
    logic [15:0]        r_as;
    logic               r_cos_neg;
    logic               r_sin_neg;
    logic               r_neg_r;
    logic signed [15:0] r_r;
    logic [1:0]         r_step;
    logic signed [15:0] r_t1;
    logic [15:0]        r_ang;
    logic               r_done;
    t_fpa_out           r_res;

    logic [15:0]        w_ac_in;
    logic [15:0]        w_as_in;
    logic               w_take;
    logic               w_div_start;
    logic [7:0]         w_div_num;
    logic [8:0]         w_div_den;
    t_div_stat          w_div_stat;
    logic [14:0]        w_quot;
    logic [15:0]        w_rmag;
    logic               w_mul_en;
    logic signed [15:0] w_mul_a;
    logic signed [15:0] w_mul_b;
    logic signed [15:0] w_mul_p;
    logic [15:0]        w_poly;
    logic [16:0]        w_round;
    logic [15:0]        w_fix_c;
    logic [15:0]        w_fix_s;

    assign w_ac_in = i_req.cos_in[15] ? (16'd0 - $unsigned(i_req.cos_in))
                                      : $unsigned(i_req.cos_in);
    assign w_as_in = i_req.sin_in[15] ? (16'd0 - $unsigned(i_req.sin_in))
                                      : $unsigned(i_req.sin_in);
    assign w_take  = start && (r_state == S_IDLE);

    assign w_div_start = (r_state == S_DIV);
    assign w_div_num   = r_neg_r ? (r_as[7:0] - r_ac[7:0]) : (r_ac[7:0] - r_as[7:0]);
    assign w_div_den   = {1'b0, r_ac[7:0]} + {1'b0, r_as[7:0]};

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    assign w_rmag = (w_quot == Q_FULL) ? R_SAT : {w_quot, 1'b0};

    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = r_r;
                w_mul_b = r_r;
            end
            2'd1: begin
                w_mul_a = w_mul_p;
                w_mul_b = r_r;
            end
            2'd2: begin
                w_mul_a = K_CUBE;
                w_mul_b = w_mul_p;
            end
            default: begin
                w_mul_a = K_LIN;
                w_mul_b = r_r;
            end
        endcase
    end

    assign w_mul_en = (r_state == S_MUL);

    fpa_mulrnd u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    assign w_poly  = $unsigned(r_t1) - $unsigned(w_mul_p) + Q15_QPI;
    assign w_round = {1'b0, w_poly} + 17'd2;
    assign w_fix_c = r_cos_neg ? (Q13_PI - r_ang) : r_ang;
    assign w_fix_s = r_sin_neg ? (Q13_TWO_PI - w_fix_c) : w_fix_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_ac      <= w_ac_in;
                        r_as      <= w_as_in;
                        r_cos_neg <= i_req.cos_in[15];
                        r_sin_neg <= i_req.sin_in[15];
                        if ((w_ac_in == 16'd0) && (w_as_in == 16'd0)) begin
                            r_res.angle_q13   <= ZERO_ANGLE;
                            r_res.zero_vector <= 1'b1;
                            r_done            <= 1'b1;
                        end else begin
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    if ((r_ac > SCALE_LIM) || (r_as > SCALE_LIM)) begin
                        r_ac <= {1'b0, r_ac[15:1]};
                        r_as <= {1'b0, r_as[15:1]};
                    end else begin
                        r_neg_r <= r_as > r_ac;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_stat.done) begin
                        r_r     <= r_neg_r ? -$signed(w_rmag) : $signed(w_rmag);
                        r_step  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == 2'd3) begin
                        r_t1    <= w_mul_p;
                        r_state <= S_SUM;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_SUM: begin
                    r_ang   <= {1'b0, w_round[16:2]};
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_res.angle_q13   <= w_fix_s;
                    r_res.zero_vector <= 1'b0;
                    r_done            <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `FPA_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `FPA_ASSERT_NEXT(a_zero_answer, i_clk, i_rst_n,
        w_take && (i_req.cos_in == 16'sd0) && (i_req.sin_in == 16'sd0),
        o_done && o_res.zero_vector, "zero vector not answered")
    `FPA_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n,
        w_take && ((i_req.cos_in != 16'sd0) || (i_req.sin_in != 16'sd0)),
        busy, "request not started")
    `FPA_ASSERT_NOW(a_done_src, i_clk, i_rst_n, o_done && !o_res.zero_vector,
        $past(r_state == S_FIX), "angle strobe without finishing")
    `FPA_ASSERT_NOW(a_div_only_wait, i_clk, i_rst_n, w_div_stat.busy,
        r_state == S_DIV_WAIT, "divider running outside its wait state")

endmodule

[sim/fixed_point_atan2_q13_tb.sv]
// Self-checking testbench for the fixed-point four-quadrant atan2 block.
// Directed and random vectors are scored against an angle predictor built in.
// Depends on fpa_pkg and the fixed_point_atan2_q13 top level.
module fixed_point_atan2_q13_tb import fpa_pkg::*; ();

    typedef struct {
        t_fpa_in     req;
        int unsigned idle_pct;
        bit          drain;
    } t_req_slot;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_fpa_in  i_req;
    logic     busy;
    logic     o_done;
    t_fpa_out o_res;

    t_req_slot   req_fifo[$];
    t_fpa_out    angle_q[$];
    bit          took_req;
    int unsigned n_taken;
    int unsigned n_checked;
    int unsigned n_zero;
    int unsigned n_errors;

    fixed_point_atan2_q13 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint round_q15(longint x);
        return (x + longint'(HALF_Q15)) >>> 15;
    endfunction

    function automatic t_fpa_out predict_angle(t_fpa_in req);
        int          mag_c;
        int          mag_s;
        int          peak;
        int          num;
        int          den;
        int          q1;
        int          rem;
        int          q2;
        int          ratio;
        longint      r2;
        longint      r3;
        longint      t1;
        longint      t2;
        logic [15:0] ang;
        t_fpa_out    res;

        mag_c = int'(req.cos_in);
        mag_s = int'(req.sin_in);
        if (mag_c < 0) mag_c = -mag_c;
        if (mag_s < 0) mag_s = -mag_s;
        peak = (mag_c > mag_s) ? mag_c : mag_s;
        while (peak > int'(SCALE_LIM)) begin
            peak  = peak >>> 1;
            mag_c = mag_c >>> 1;
            mag_s = mag_s >>> 1;
        end
        num = (mag_c - mag_s) * 128;
        den = mag_c + mag_s;
        if (den == 0) begin
            res.angle_q13   = ZERO_ANGLE;
            res.zero_vector = 1'b1;
            return res;
        end
        q1    = num / den;
        rem   = num % den;
        q2    = (128 * rem) / den;
        ratio = (q1 * 128 + q2) * 2;
        if (ratio > int'(R_SAT)) ratio = int'(R_SAT);
        if (ratio < -int'(R_SAT)) ratio = -int'(R_SAT);
        r2  = round_q15(longint'(ratio) * ratio);
        r3  = round_q15(r2 * ratio);
        t1  = round_q15(longint'(K_CUBE) * r3);
        t2  = round_q15(longint'(K_LIN) * ratio);
        ang = 16'(t1 - t2 + longint'(Q15_QPI));
        ang = 16'((int'(ang) + 2) >> 2);
        if (req.cos_in < 0) ang = Q13_PI - ang;
        if (req.sin_in < 0) ang = Q13_TWO_PI - ang;
        res.angle_q13   = ang;
        res.zero_vector = 1'b0;
        return res;
    endfunction

    function automatic void queue_req(int c, int s, int unsigned pct, bit drain);
        t_req_slot slot;
        slot.req.cos_in = 16'(c);
        slot.req.sin_in = 16'(s);
        slot.idle_pct   = pct;
        slot.drain      = drain;
        req_fifo.push_back(slot);
    endfunction

    function automatic void queue_random(int unsigned pct, bit drain);
        int c;
        int s;
        c = int'($signed(16'($urandom)));
        s = int'($signed(16'($urandom)));
        case ($urandom_range(0, 9))
            5, 6: begin
                c = int'($urandom_range(0, 511)) - 256;
                s = int'($urandom_range(0, 511)) - 256;
            end
            7: begin
                if ($urandom_range(0, 1) == 0) c = 0;
                else s = 0;
            end
            8: begin
                s = ($urandom_range(0, 1) == 0) ? c : -c;
                s = s + int'($urandom_range(0, 6)) - 3;
                if (s > 32767) s = 32767;
                if (s < -32768) s = -32768;
            end
            9: begin
                if ($urandom_range(0, 3) == 0) begin
                    c = 0;
                    s = 0;
                end
            end
            default: ;
        endcase
        queue_req(c, s, pct, drain);
    endfunction

    // Requests enter on the falling edge; start stays high until the block takes it.
    always @(negedge i_clk) begin : drive_req
        logic      next_start;
        t_fpa_in   next_req;
        t_req_slot slot;

        next_start = start;
        next_req   = i_req;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && took_req) next_start = 1'b0;
            if (!next_start && req_fifo.size() > 0) begin
                if (req_fifo[0].drain && angle_q.size() > 0) begin
                    next_start = 1'b0;
                end else if ($urandom_range(0, 99) >= req_fifo[0].idle_pct) begin
                    slot       = req_fifo.pop_front();
                    next_start = 1'b1;
                    next_req   = slot.req;
                end
            end
        end
        start <= next_start;
        i_req <= next_req;
    end

    always @(posedge i_clk) begin : observe
        t_fpa_out want;

        took_req = i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            if (angle_q.size() == 0) begin
                $error("unexpected result: angle_q13 %0d zero_vector %0b",
                       o_res.angle_q13, o_res.zero_vector);
                n_errors++;
            end else begin
                want = angle_q.pop_front();
                n_checked++;
                if (want.zero_vector) n_zero++;
                if (o_res.angle_q13 !== want.angle_q13) begin
                    $error("angle_q13 expected %0d actual %0d",
                           want.angle_q13, o_res.angle_q13);
                    n_errors++;
                end
                if (o_res.zero_vector !== want.zero_vector) begin
                    $error("zero_vector expected %0b actual %0b",
                           want.zero_vector, o_res.zero_vector);
                    n_errors++;
                end
            end
        end
        if (took_req) begin
            angle_q.push_back(predict_angle(i_req));
            n_taken++;
        end
    end

    initial begin : run_test
        int unsigned phase_pct[4];
        int          directed[22][2];

        phase_pct = '{0, 64, 0, 16};
        directed  = '{
            '{0, 0}, '{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32767},
            '{-32767, 0}, '{32767, 32767}, '{-32768, -32768}, '{1, 0}, '{0, 1},
            '{1, 1}, '{-1, -1}, '{128, 128}, '{129, -1}, '{-1, 129},
            '{100, -37}, '{-32768, 32767}, '{32767, -32768}, '{1, -1},
            '{0, -32768}, '{255, 1}, '{3, -200}
        };
        start    = 1'b0;
        i_req    = '0;
        i_rst_n  = 1'b0;
        took_req = 1'b0;
        n_taken  = 0;
        n_checked = 0;
        n_zero   = 0;
        n_errors = 0;

        foreach (directed[k]) queue_req(directed[k][0], directed[k][1], 0, 1'b0);
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 150; k++) queue_random(phase_pct[p], k == 0);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_fifo.size() > 0 || start) @(posedge i_clk);
        while (angle_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d requests (%0d zero vectors), %0d results checked,",
                 n_taken, n_zero, n_checked);
        $display("across four phases of sender idling with one full drain between.");
        if (n_errors == 0 && angle_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
